// File: src/ttx_rad_pkg.sv
package ttx_rad_pkg;

	localparam int ROW_CELLS           = 40;
	localparam int HEADER_FIRST_COLUMN = 8;
	localparam int LAST_ROW            = 25;
	localparam int MAP_ROWS            = LAST_ROW + 1;

	localparam logic [5:0] LAST_COLUMN  = 6'(ROW_CELLS - 1);
	localparam logic [5:0] HEADER_COL   = 6'(HEADER_FIRST_COLUMN);
	localparam logic [4:0] LAST_ROW_NUM = 5'(LAST_ROW);
	localparam logic [6:0] SPACE_CHAR   = 7'h20;
	localparam logic [2:0] WHITE        = 3'd7;
	localparam logic [2:0] BLACK        = 3'd0;

	typedef enum logic [1:0] {
		OP_DATA       = 2'd0,
		OP_ROW_START  = 2'd1,
		OP_PAGE_START = 2'd2
	} opcode_t;

	typedef enum logic {
		CFG_SECOND_CHARSET = 1'b0,
		CFG_DEFAULT_UPPER  = 1'b1
	} cfg_index_t;

	localparam logic [4:0] ATTR_ALPHA_FIRST  = 5'h00;
	localparam logic [4:0] ATTR_ALPHA_LAST   = 5'h07;
	localparam logic [4:0] ATTR_FLASH        = 5'h08;
	localparam logic [4:0] ATTR_STEADY       = 5'h09;
	localparam logic [4:0] ATTR_END_BOX      = 5'h0A;
	localparam logic [4:0] ATTR_START_BOX    = 5'h0B;
	localparam logic [4:0] ATTR_NORMAL_SIZE  = 5'h0C;
	localparam logic [4:0] ATTR_DOUBLE_HGT   = 5'h0D;
	localparam logic [4:0] ATTR_DOUBLE_WID   = 5'h0E;
	localparam logic [4:0] ATTR_DOUBLE_SIZE  = 5'h0F;
	localparam logic [4:0] ATTR_MOSAIC_FIRST = 5'h10;
	localparam logic [4:0] ATTR_MOSAIC_LAST  = 5'h17;
	localparam logic [4:0] ATTR_CONCEAL      = 5'h18;
	localparam logic [4:0] ATTR_CONTIGUOUS   = 5'h19;
	localparam logic [4:0] ATTR_SEPARATED    = 5'h1A;
	localparam logic [4:0] ATTR_ESCAPE       = 5'h1B;
	localparam logic [4:0] ATTR_BLACK_BG     = 5'h1C;
	localparam logic [4:0] ATTR_NEW_BG       = 5'h1D;
	localparam logic [4:0] ATTR_HOLD         = 5'h1E;
	localparam logic [4:0] ATTR_RELEASE      = 5'h1F;

	localparam int MB_FLASH   = 0;
	localparam int MB_CONCEAL = 1;
	localparam int MB_SEP     = 2;
	localparam int MB_MOSAIC  = 3;
	localparam int MB_G0      = 4;
	localparam int MB_HOLD    = 5;

	typedef struct packed {
		logic [2:0] fg;
		logic [2:0] bg;
		logic [5:0] mode;
		logic [2:0] box;
		logic [1:0] size;
		logic [6:0] held_char;
		logic       held_sep;
	} attr_state_t;

	localparam attr_state_t ATTR_RESET = '{
		fg:        WHITE,
		bg:        BLACK,
		mode:      6'd0,
		box:       3'd0,
		size:      2'd0,
		held_char: SPACE_CHAR,
		held_sep:  1'b0
	};

	typedef struct packed {
		logic [6:0] character;
		logic [2:0] fg_ink;
		logic [2:0] bg_ink;
		logic [1:0] size_mode;
		logic [7:0] charset;
		logic [5:0] attr_code;
		logic [4:0] flags;
	} cell_t;

endpackage

// File: src/ttx_rad_attr.sv
module ttx_rad_attr (
	input  ttx_rad_pkg::attr_state_t st,
	input  logic [7:0]               raw,
	input  logic [7:0]               second_charset,
	input  logic [4:0]               default_upper,
	input  logic [2:0]               national,
	output ttx_rad_pkg::attr_state_t st_next,
	output ttx_rad_pkg::cell_t       glyph,
	output logic                     mark_below
);
	import ttx_rad_pkg::*;

	logic [6:0] d;
	logic [4:0] code;
	logic       flash, conceal, win, sep, mos;
	logic       size_cmd;
	logic [1:0] size_val;

	assign d    = {raw[1], raw[2], raw[3], raw[4], raw[5], raw[6], raw[7]};
	assign code = d[4:0];

	always_comb begin
		st_next    = st;
		mark_below = 1'b0;
		size_cmd   = 1'b0;
		size_val   = 2'd0;
		flash      = st.mode[MB_FLASH];
		conceal    = st.mode[MB_CONCEAL];
		win        = st.box >= 3'd2;
		sep        = st.mode[MB_SEP];
		mos        = st.mode[MB_MOSAIC];
		glyph.character = SPACE_CHAR;
		glyph.fg_ink    = st.fg;
		glyph.bg_ink    = st.bg;
		glyph.size_mode = st.size;
		glyph.charset   = st.mode[MB_G0] ? second_charset : {default_upper, national};
		glyph.attr_code = 6'd0;
		if (d[6:5] != 2'b00) begin
			glyph.character = d;
			if (mos) begin
				st_next.held_char = d;
				st_next.held_sep  = sep;
			end
		end else begin
			glyph.attr_code = 6'(code) + 6'd1;
			if (st.mode[MB_HOLD]) begin
				glyph.character = st.held_char;
				sep             = st.held_sep;
				mos             = 1'b1;
			end
			case (code) inside
				[ATTR_ALPHA_FIRST:ATTR_ALPHA_LAST]: begin
					st_next.fg               = code[2:0];
					st_next.mode[MB_MOSAIC]  = 1'b0;
					st_next.mode[MB_CONCEAL] = 1'b0;
					st_next.held_char        = SPACE_CHAR;
				end
				[ATTR_MOSAIC_FIRST:ATTR_MOSAIC_LAST]: begin
					st_next.fg               = code[2:0];
					st_next.mode[MB_MOSAIC]  = 1'b1;
					st_next.mode[MB_CONCEAL] = 1'b0;
				end
				ATTR_FLASH: st_next.mode[MB_FLASH] = 1'b1;
				ATTR_STEADY: begin
					st_next.mode[MB_FLASH] = 1'b0;
					flash                  = 1'b0;
				end
				ATTR_END_BOX: begin
					if (st.box == 3'd2 || st.box == 3'd3) st_next.box = st.box + 3'd1;
				end
				ATTR_START_BOX: begin
					if (st.box < 3'd2) st_next.box = st.box + 3'd1;
				end
				ATTR_NORMAL_SIZE: begin
					size_cmd        = 1'b1;
					size_val        = 2'd0;
					glyph.size_mode = 2'd0;
				end
				ATTR_DOUBLE_HGT: begin
					size_cmd = 1'b1;
					size_val = 2'd1;
				end
				ATTR_DOUBLE_WID: begin
					size_cmd = 1'b1;
					size_val = 2'd2;
				end
				ATTR_DOUBLE_SIZE: begin
					size_cmd = 1'b1;
					size_val = 2'd3;
				end
				ATTR_CONCEAL: begin
					st_next.mode[MB_CONCEAL] = 1'b1;
					conceal                  = 1'b1;
				end
				ATTR_CONTIGUOUS: begin
					st_next.mode[MB_SEP] = 1'b0;
					sep                  = 1'b0;
				end
				ATTR_SEPARATED: begin
					st_next.mode[MB_SEP] = 1'b1;
					sep                  = 1'b1;
				end
				ATTR_ESCAPE: st_next.mode[MB_G0] = ~st.mode[MB_G0];
				ATTR_BLACK_BG: begin
					st_next.bg   = BLACK;
					glyph.bg_ink = BLACK;
				end
				ATTR_NEW_BG: begin
					st_next.bg   = st.fg;
					glyph.bg_ink = st.fg;
				end
				ATTR_HOLD: begin
					st_next.mode[MB_HOLD] = 1'b1;
					glyph.character       = st.held_char;
					sep                   = st.held_sep;
					mos                   = 1'b1;
				end
				ATTR_RELEASE: st_next.mode[MB_HOLD] = 1'b0;
				default: ;
			endcase
			if (size_cmd) begin
				if (st.size != size_val) st_next.held_char = SPACE_CHAR;
				st_next.size = size_val;
				mark_below   = size_val[0];
			end
		end
		glyph.flags = {mos, sep, win, conceal, flash};
	end

endmodule

// File: src/teletext_row_attribute_decoder.sv
// Channel   Transfer when          Payload
// s_*       s_tvalid & s_tready    tuser opcode; tdata row_number, data_byte, national_option
// m_*       m_tvalid & m_tready    tdata display fields; tlast row_end
// cfg_*     cfg_wr_en              cfg_index selects register, cfg_wdata value
//
// One item a cycle while s_tready is high: each item passes through the input stage, where the attribute
// logic updates the row state and loads the output register.
// A data byte of an open row is registered in the input stage and then in the output register,
// which raises m_tvalid; other items yield none.
// s_tready drops only while such a byte sits in the input stage behind an unaccepted output.
// arst_n clears all row, attribute and skip-map state and the configuration.
module teletext_row_attribute_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // row_number[4:0], data_byte[12:5], national_option[15:13]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// row[4:0], column[10:5], character[17:11], fg_ink[20:18], bg_ink[23:21],
	// size_mode[25:24], charset[33:26], attr_code[39:34], flags[44:40], copy_below[45]
	output logic [47:0] m_tdata,
	output logic        m_tlast,   // row_end
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);
	import ttx_rad_pkg::*;

	logic [7:0]  second_charset_q;
	logic [4:0]  default_upper_q;

	logic        valid_s1;
	opcode_t     op_s1;
	logic [4:0]  rn_s1;
	logic [7:0]  byte_s1;
	logic [2:0]  nat_s1;

	logic [4:0]          row_q;
	logic [5:0]          col_q;
	logic                active_q;
	attr_state_t         st_q;
	logic [MAP_ROWS-1:0] skip_q;
	logic [2:0]          nat_q;

	logic        out_valid_q;
	logic [47:0] out_data_q;
	logic        out_last_q;

	attr_state_t         st_next;
	attr_state_t         row_defaults;
	cell_t               glyph;
	logic                mark_below;
	logic [MAP_ROWS-1:0] skip_next;
	logic [31:0]         skip_q_wide;
	logic [31:0]         skip_next_wide;
	logic                emits;
	logic                advance;
	logic                row_end;
	logic                copy_below;
	logic                row_ok;

	ttx_rad_attr u_attr (
		.st             (st_q),
		.raw            (byte_s1),
		.second_charset (second_charset_q),
		.default_upper  (default_upper_q),
		.national       (nat_q),
		.st_next        (st_next),
		.glyph          (glyph),
		.mark_below     (mark_below)
	);

	always_comb begin
		row_defaults          = ATTR_RESET;
		row_defaults.held_sep = st_q.held_sep;
		skip_next = skip_q;
		if (mark_below && row_q < LAST_ROW_NUM)
			skip_next = skip_q | (MAP_ROWS'(2) << row_q);
		skip_q_wide    = 32'(skip_q);
		skip_next_wide = 32'(skip_next);
		row_ok     = (rn_s1 <= LAST_ROW_NUM) && !skip_q_wide[rn_s1];
		row_end    = col_q >= LAST_COLUMN;
		copy_below = row_end && (row_q < LAST_ROW_NUM) && skip_next_wide[row_q + 5'd1];
	end

	assign emits    = valid_s1 && (op_s1 == OP_DATA) && active_q;
	assign advance  = valid_s1 && (!emits || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_charset_q <= 8'd0;
			default_upper_q  <= 5'd0;
		end else if (cfg_wr_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_SECOND_CHARSET: second_charset_q <= cfg_wdata;
				CFG_DEFAULT_UPPER:  default_upper_q  <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= opcode_t'(s_tuser);
			rn_s1   <= s_tdata[4:0];
			byte_s1 <= s_tdata[12:5];
			nat_s1  <= s_tdata[15:13];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= 5'd0;
			col_q    <= 6'd0;
			active_q <= 1'b0;
			st_q     <= ATTR_RESET;
			skip_q   <= '0;
			nat_q    <= 3'd0;
		end else if (advance) begin
			case (op_s1)
				OP_PAGE_START: skip_q <= '0;
				OP_ROW_START: begin
					active_q <= row_ok;
					if (row_ok) begin
						row_q <= rn_s1;
						st_q  <= row_defaults;
						if (rn_s1 == 5'd0) begin
							col_q <= HEADER_COL;
							nat_q <= nat_s1;
						end else begin
							col_q <= 6'd0;
						end
					end
				end
				OP_DATA: begin
					if (active_q) begin
						st_q   <= st_next;
						skip_q <= skip_next;
						if (row_end) active_q <= 1'b0;
						else col_q <= col_q + 6'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emits) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emits) begin
			out_data_q <= {2'b00, copy_below, glyph.flags, glyph.attr_code, glyph.charset,
				glyph.size_mode, glyph.bg_ink, glyph.fg_ink, glyph.character, col_q, row_q};
			out_last_q <= row_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// File: src/ttx_rad_checker.sv
module ttx_rad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tlast
);
	import ttx_rad_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled cell changed");

	a_copy_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[45] |-> m_tlast && m_tdata[4:0] < LAST_ROW_NUM)
		else $error("copy_below off the last cell of a row");

	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[10:5] <= LAST_COLUMN && m_tdata[4:0] <= LAST_ROW_NUM
			&& (m_tlast == (m_tdata[10:5] == LAST_COLUMN)))
		else $error("cell position out of range");

	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[39:34] == 6'd0 |-> m_tdata[17:16] != 2'b00)
		else $error("printable cell with control code");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with no output stall");

endmodule

bind teletext_row_attribute_decoder ttx_rad_checker u_ttx_rad_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
